// File: hdl/pgm_pkg.sv
// Shared types and constants of the prioritised gain mixer.
package pgm_pkg;

   localparam int NUM_SRC    = 4;
   localparam int SRC_IDX_W  = $clog2(NUM_SRC);
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 16;
   localparam int PRIO_W     = 4;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;
   // accept edge to strobe: input register, product register, one fold stage per source
   localparam int PIPE_LAT   = NUM_SRC + 2;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'h8000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [GAIN_W-1:0]          gain_type;
   typedef logic [SRC_IDX_W-1:0]       src_idx_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_SRC0   = 3'd0,
      CSR_GAIN_SRC1   = 3'd1,
      CSR_GAIN_SRC2   = 3'd2,
      CSR_GAIN_SRC3   = 3'd3,
      CSR_MASTER_GAIN = 3'd4,
      CSR_MUTE_MASK   = 3'd5,
      CSR_PRIORITY    = 3'd6
   } csr_index_type;

endpackage

// File: hdl/prioritized_gain_mixer.sv
// Prioritised four-source PCM gain mixer with fold-back saturation.
//
//   channel  ports                              transfer when
//   -------  ---------------------------------  ---------------------------
//   request  start, busy, req_sample_src0..3,   start high, busy low
//            req_present_mask
//   result   rsp_strobe, rsp_mixed_sample       rsp_strobe high (one cycle)
//   csr      csr_write_en, csr_index, csr_wdata csr_write_en high
//
// One item per clock while reset is low. The result is registered through an
// input register, a register after the sample x gain multipliers, then one
// fold stage per source in priority order.
// An item with an empty present mask yields no result.
// Synchronous reset empties the pipe; busy is high only while reset is held.
// The receiver cannot stall, so nothing is ever held back.
module prioritized_gain_mixer
   import pgm_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [SAMPLE_W-1:0]    req_sample_src0,
   input  logic [SAMPLE_W-1:0]    req_sample_src1,
   input  logic [SAMPLE_W-1:0]    req_sample_src2,
   input  logic [SAMPLE_W-1:0]    req_sample_src3,
   input  logic [NUM_SRC-1:0]     req_present_mask,
   output logic                   rsp_strobe,
   output logic [SAMPLE_W-1:0]    rsp_mixed_sample,
   input  logic                   csr_write_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int F    = GAIN_FRAC_BITS;
   localparam int GW   = 2 * GAIN_W - F;           // combined gain width
   localparam int PW   = SAMPLE_W + GW + 1;        // signed product width
   localparam int TW   = PW - F;                   // term width after the shift
   localparam int SW   = ((TW > SAMPLE_W) ? TW : SAMPLE_W) + 1;
   localparam int HW   = SW + 2;
   localparam logic [2*GAIN_W-1:0] UNITY_SQ = {GAIN_UNITY, {GAIN_W{1'b0}}} >> 1;
   localparam logic [GW-1:0] G_RESET = GW'(UNITY_SQ >> F);
   localparam logic signed [SW-1:0] S_MAX = SW'(32767);
   localparam logic signed [SW-1:0] S_MIN = -SW'(32768);
   localparam logic signed [HW-1:0] H_MAX = HW'(32767);
   localparam logic signed [HW-1:0] H_MIN = -HW'(32768);
   localparam logic signed [HW-1:0] H_HI  = HW'(98301);
   localparam logic signed [HW-1:0] H_LO  = -HW'(98304);

   // fold overshoot back by half, truncate toward zero, clamp
   function automatic sample_type fold_f(input logic signed [SW-1:0] s);
      logic signed [HW-1:0] h;
      logic signed [HW-1:0] v;
      h = HW'(s);
      if (s > S_MAX) begin
         h = H_HI - HW'(s);
      end else if (s < S_MIN) begin
         h = H_LO - HW'(s);
      end
      if (s > S_MAX || s < S_MIN) begin
         v = h[HW-1] ? ((h + HW'(1)) >>> 1) : (h >>> 1);
         if (v > H_MAX) begin
            v = H_MAX;
         end
         if (v < H_MIN) begin
            v = H_MIN;
         end
      end else begin
         v = h;
      end
      return sample_type'(v[SAMPLE_W-1:0]);
   endfunction

   // configuration registers
   gain_type                      gain_ff   [NUM_SRC];
   gain_type                      gain_in   [NUM_SRC];
   gain_type                      master_ff, master_in;
   logic [NUM_SRC-1:0]            mute_ff, mute_in;
   logic [NUM_SRC*PRIO_W-1:0]     prio_ff, prio_in;

   // derived from configuration: combined gains and mixing order
   logic [GW-1:0]                 g_ff      [NUM_SRC];
   logic [GW-1:0]                 g_in      [NUM_SRC];
   src_idx_type                   order_ff  [NUM_SRC];
   src_idx_type                   order_in  [NUM_SRC];
   src_idx_type                   rank      [NUM_SRC];
   logic [2*GAIN_W-1:0]           g_full    [NUM_SRC];

   // input register
   logic                          vld_a_ff, vld_a_in;
   logic [NUM_SRC-1:0]            act_a_ff;
   sample_type                    smp_a_ff  [NUM_SRC];
   sample_type                    smp_in    [NUM_SRC];

   // fold chain: stage 0 is the product register
   logic                          vld_ff    [NUM_SRC+1];
   logic [NUM_SRC-1:0]            act_ff    [NUM_SRC+1];
   sample_type                    acc_ff    [NUM_SRC+1];
   logic signed [TW-1:0]          term_ff   [NUM_SRC+1][NUM_SRC];
   logic signed [PW-1:0]          prod      [NUM_SRC];

   assign busy = reset;

   always_comb begin
      for (int n = 0; n < NUM_SRC; n++) begin
         gain_in[n] = gain_ff[n];
      end
      master_in = master_ff;
      mute_in   = mute_ff;
      prio_in   = prio_ff;
      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_SRC0: begin
               gain_in[0] = csr_wdata;
            end
            CSR_GAIN_SRC1: begin
               gain_in[1] = csr_wdata;
            end
            CSR_GAIN_SRC2: begin
               gain_in[2] = csr_wdata;
            end
            CSR_GAIN_SRC3: begin
               gain_in[3] = csr_wdata;
            end
            CSR_MASTER_GAIN: begin
               master_in = csr_wdata;
            end
            CSR_MUTE_MASK: begin
               mute_in = csr_wdata[NUM_SRC-1:0];
            end
            CSR_PRIORITY: begin
               prio_in = csr_wdata[NUM_SRC*PRIO_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // rank: sources ahead by higher priority, or equal priority and lower index
   always_comb begin
      for (int n = 0; n < NUM_SRC; n++) begin
         g_full[n] = gain_ff[n] * master_ff;
         g_in[n]   = g_full[n][2*GAIN_W-1:F];
         rank[n]   = '0;
         for (int m = 0; m < NUM_SRC; m++) begin
            if ((prio_ff[m*PRIO_W +: PRIO_W] > prio_ff[n*PRIO_W +: PRIO_W]) ||
                ((prio_ff[m*PRIO_W +: PRIO_W] == prio_ff[n*PRIO_W +: PRIO_W]) &&
                 (m < n))) begin
               rank[n] = rank[n] + src_idx_type'(1);
            end
         end
      end
      for (int k = 0; k < NUM_SRC; k++) begin
         order_in[k] = '0;
         for (int n = 0; n < NUM_SRC; n++) begin
            if (rank[n] == src_idx_type'(k)) begin
               order_in[k] = src_idx_type'(n);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NUM_SRC; n++) begin
            gain_ff[n]  <= GAIN_UNITY;
            g_ff[n]     <= G_RESET;
            order_ff[n] <= src_idx_type'(n);
         end
         master_ff <= GAIN_UNITY;
         mute_ff   <= '0;
         prio_ff   <= '0;
      end else begin
         for (int n = 0; n < NUM_SRC; n++) begin
            gain_ff[n]  <= gain_in[n];
            g_ff[n]     <= g_in[n];
            order_ff[n] <= order_in[n];
         end
         master_ff <= master_in;
         mute_ff   <= mute_in;
         prio_ff   <= prio_in;
      end
   end

   // input stage
   assign smp_in[0] = req_sample_src0;
   assign smp_in[1] = req_sample_src1;
   assign smp_in[2] = req_sample_src2;
   assign smp_in[3] = req_sample_src3;
   assign vld_a_in  = start && !busy && (req_present_mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else begin
         vld_a_ff <= vld_a_in;
      end
      for (int n = 0; n < NUM_SRC; n++) begin
         smp_a_ff[n] <= smp_in[n];
      end
      act_a_ff <= req_present_mask & ~mute_ff;
   end

   // product stage: floor shift is an arithmetic right shift
   always_comb begin
      for (int n = 0; n < NUM_SRC; n++) begin
         prod[n] = PW'(smp_a_ff[n]) * $signed({1'b0, g_ff[n]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= vld_a_ff;
      end
      act_ff[0] <= act_a_ff;
      acc_ff[0] <= '0;
      for (int n = 0; n < NUM_SRC; n++) begin
         term_ff[0][n] <= prod[n][PW-1:F];
      end
   end

   // fold stages, one source per stage in mixing order
   for (genvar k = 0; k < NUM_SRC; k++) begin : g_fold
      src_idx_type          sel;
      logic signed [TW-1:0] add;
      logic signed [SW-1:0] sum;
      sample_type           acc_in;

      assign sel    = order_ff[k];
      assign add    = act_ff[k][sel] ? term_ff[k][sel] : '0;
      assign sum    = SW'(acc_ff[k]) + SW'(add);
      assign acc_in = act_ff[k][sel] ? fold_f(sum) : acc_ff[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         act_ff[k+1] <= act_ff[k];
         acc_ff[k+1] <= acc_in;
         for (int n = 0; n < NUM_SRC; n++) begin
            term_ff[k+1][n] <= term_ff[k][n];
         end
      end
   end

   assign rsp_strobe       = vld_ff[NUM_SRC];
   assign rsp_mixed_sample = acc_ff[NUM_SRC];

endmodule

// File: hdl/pgm_checker.sv
// Port-level checks of the prioritised gain mixer, bound to the top level.
module pgm_checker
   import pgm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [NUM_SRC-1:0] req_present_mask,
   input  logic               rsp_strobe
);

   logic take;

   assign take = start && !busy && (req_present_mask != '0);

   // reset empties the pipe
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   // every transfer with a source present gives exactly one result, at fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      take |-> ##PIPE_LAT rsp_strobe)
      else $error("result lost");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !take |-> ##PIPE_LAT !rsp_strobe)
      else $error("result without a matching transfer");

   a_not_busy: assert property (@(posedge clock)
      !reset |-> !busy)
      else $error("busy outside reset");

endmodule

bind prioritized_gain_mixer pgm_checker u_pgm_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_present_mask (req_present_mask),
   .rsp_strobe       (rsp_strobe)
);

// File: tb/sv/tb_prioritized_gain_mixer.sv
// Self-checking testbench for the prioritised gain mixer: directed table, then random phases.
`timescale 1ns / 1ps

module tb_prioritized_gain_mixer
   import pgm_pkg::*;
;

   localparam int GAIN_FRAC     = 15;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = 190;
   localparam longint SMAX      = 32767;
   localparam longint SMIN      = -32768;
   // index with no register behind it: writes are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = 3'd7;

   typedef struct packed {
      logic [NUM_SRC-1:0][SAMPLE_W-1:0] smp;
      logic [NUM_SRC-1:0]               present;
   } mix_item_type;

   typedef struct {
      bit                    is_cfg;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] wdata;
      mix_item_type          item;
      bit                    typed;
      sample_type            typed_val;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [SAMPLE_W-1:0]   req_sample_src0 = '0;
   logic [SAMPLE_W-1:0]   req_sample_src1 = '0;
   logic [SAMPLE_W-1:0]   req_sample_src2 = '0;
   logic [SAMPLE_W-1:0]   req_sample_src3 = '0;
   logic [NUM_SRC-1:0]    req_present_mask = '0;
   logic                  rsp_strobe;
   logic [SAMPLE_W-1:0]   rsp_mixed_sample;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // local copy of the register file
   gain_type              gain_copy [NUM_SRC];
   gain_type              master_copy;
   logic [NUM_SRC-1:0]    mute_copy;
   logic [15:0]           prio_copy;

   sample_type            mixed_expect_q [$];
   stim_row_type          dir_tab [$];
   int                    mismatch_count = 0;
   int                    cycle_count = 0;

   prioritized_gain_mixer u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_sample_src0  (req_sample_src0),
      .req_sample_src1  (req_sample_src1),
      .req_sample_src2  (req_sample_src2),
      .req_sample_src3  (req_sample_src3),
      .req_present_mask (req_present_mask),
      .rsp_strobe       (rsp_strobe),
      .rsp_mixed_sample (rsp_mixed_sample),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Mix of the present, unmuted sources in priority order; returns 0 when nothing is present.
   function automatic bit mix_predict(input mix_item_type it, output sample_type mixed);
      longint acc, comb, term, h, v;
      int     pri, n;
      acc = 0;
      for (pri = 15; pri >= 0; pri--) begin
         for (n = 0; n < NUM_SRC; n++) begin
            if (!it.present[n] || mute_copy[n])
               continue;
            if (int'(prio_copy[PRIO_W*n +: PRIO_W]) != pri)
               continue;
            comb = (longint'(gain_copy[n]) * longint'(master_copy)) >>> GAIN_FRAC;
            term = (longint'(sample_type'(it.smp[n])) * comb) >>> GAIN_FRAC;
            acc  = acc + term;
            if (acc > SMAX || acc < SMIN) begin
               // fold the overshoot back by half, then truncate toward zero
               if (acc > SMAX)
                  h = 2 * SMAX - (acc - SMAX);
               else
                  h = 2 * SMIN + (SMIN - acc);
               v = h / 2;
               if (v > SMAX)
                  v = SMAX;
               if (v < SMIN)
                  v = SMIN;
               acc = v;
            end
         end
      end
      mixed = sample_type'(acc[SAMPLE_W-1:0]);
      return it.present != '0;
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return sample_type'($urandom_range(0, 64) - 32);
         default: return sample_type'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_gain(int ph);
      if (ph == 0)
         return 16'hFFFF;
      if (ph == 1)
         return 16'h0000;
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return GAIN_UNITY;
         2: return 16'hFFFF;
         3: return CSR_DATA_W'($urandom_range(0, 32768));
         default: return CSR_DATA_W'($urandom);
      endcase
   endfunction

   function automatic int draw_gap(bit burst);
      return burst ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic stim_row_type mix_row(int s0, int s1, int s2, int s3, int present,
                                            bit typed = 1'b0, int val = 0);
      stim_row_type r;
      r.is_cfg       = 1'b0;
      r.idx          = '0;
      r.wdata        = '0;
      r.item.smp[0]  = SAMPLE_W'(s0);
      r.item.smp[1]  = SAMPLE_W'(s1);
      r.item.smp[2]  = SAMPLE_W'(s2);
      r.item.smp[3]  = SAMPLE_W'(s3);
      r.item.present = NUM_SRC'(present);
      r.typed        = typed;
      r.typed_val    = sample_type'(val);
      return r;
   endfunction

   function automatic stim_row_type cfg_row(logic [CSR_IDX_W-1:0] idx, int data);
      stim_row_type r;
      r.is_cfg    = 1'b1;
      r.idx       = idx;
      r.wdata     = CSR_DATA_W'(data);
      r.item      = '0;
      r.typed     = 1'b0;
      r.typed_val = '0;
      return r;
   endfunction

   // Leaves csr_write_en high; the caller lowers it after the last write.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      if (idx <= CSR_GAIN_SRC3)
         gain_copy[idx] = data;
      else if (idx == CSR_MASTER_GAIN)
         master_copy = data;
      else if (idx == CSR_MUTE_MASK)
         mute_copy = data[NUM_SRC-1:0];
      else if (idx == CSR_PRIORITY)
         prio_copy = data;
   endtask

   // Called at a clock edge; returns at the edge where the transfer happens.
   task automatic send_mix(input mix_item_type it, input int gap, input bit typed,
                           input sample_type typed_val);
      sample_type mixed;
      bit         has;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_sample_src0  <= it.smp[0];
      req_sample_src1  <= it.smp[1];
      req_sample_src2  <= it.smp[2];
      req_sample_src3  <= it.smp[3];
      req_present_mask <= it.present;
      do @(posedge clock); while (busy);
      has = mix_predict(it, mixed);
      if (typed)
         mixed = typed_val;
      if (has)
         mixed_expect_q.push_back(mixed);
   endtask

   // Empty-mask items leave no trace in the queue, so also let the pipe run dry.
   task automatic wait_drained();
      start <= 1'b0;
      while (mixed_expect_q.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 2) @(posedge clock);
   endtask

   task automatic note_mismatch(string what, sample_type want, sample_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch (%s): mixed_sample expected %0d, got %0d", what, want, got);
   endtask

   always @(posedge clock) begin : result_check
      sample_type want;
      if (!reset && rsp_strobe) begin
         if (mixed_expect_q.size() == 0) begin
            note_mismatch("unexpected result", '0, sample_type'(rsp_mixed_sample));
         end else begin
            want = mixed_expect_q.pop_front();
            if (sample_type'(rsp_mixed_sample) !== want)
               note_mismatch("wrong value", want, sample_type'(rsp_mixed_sample));
         end
      end
   end

   initial begin : stimulus
      int           ph, k, n;
      bit           in_cfg, burst;
      mix_item_type it;
      stim_row_type row;

      for (n = 0; n < NUM_SRC; n++)
         gain_copy[n] = GAIN_UNITY;
      master_copy = GAIN_UNITY;
      mute_copy   = '0;
      prio_copy   = '0;

      // reset values: unity gains pass a lone sample straight through
      dir_tab.push_back(mix_row(32767, -32768, 16'h1234, -1, 0, 1'b1, 0));
      dir_tab.push_back(mix_row(32767, 0, 0, 0, 1, 1'b1, 32767));
      dir_tab.push_back(mix_row(0, -32768, 0, 0, 2, 1'b1, -32768));
      dir_tab.push_back(mix_row(0, 0, 16'h1234, 0, 4, 1'b1, 16'h1234));
      dir_tab.push_back(mix_row(0, 0, 0, -1, 8, 1'b1, -1));
      dir_tab.push_back(mix_row(32767, 32767, 0, 0, 3, 1'b1, 16383));
      dir_tab.push_back(mix_row(-32768, -32768, -32768, -32768, 15, 1'b1, -20480));
      dir_tab.push_back(mix_row(16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 15));
      dir_tab.push_back(mix_row(-32768, 32767, -1, 1, 9));
      // present but all muted
      dir_tab.push_back(cfg_row(CSR_MUTE_MASK, 16'hF));
      dir_tab.push_back(mix_row(1000, 2000, 3000, 4000, 15, 1'b1, 0));
      dir_tab.push_back(cfg_row(CSR_MUTE_MASK, 16'h5));
      dir_tab.push_back(mix_row(20000, 20000, 20000, 20000, 15));
      // upper data bits of the mute write must be dropped
      dir_tab.push_back(cfg_row(CSR_MUTE_MASK, 16'hFFF0));
      dir_tab.push_back(cfg_row(CSR_PRIORITY, 16'h0A5F));
      dir_tab.push_back(mix_row(30000, -30000, 30000, 30000, 15));
      dir_tab.push_back(mix_row(-20000, 30000, 30000, -20000, 7));
      // gains above unity, large overshoot folds across zero
      dir_tab.push_back(cfg_row(CSR_GAIN_SRC0, 16'hFFFF));
      dir_tab.push_back(cfg_row(CSR_GAIN_SRC1, 16'hFFFF));
      dir_tab.push_back(cfg_row(CSR_GAIN_SRC2, 16'hFFFF));
      dir_tab.push_back(cfg_row(CSR_GAIN_SRC3, 16'hFFFF));
      dir_tab.push_back(cfg_row(CSR_MASTER_GAIN, 16'hFFFF));
      dir_tab.push_back(mix_row(-32768, -32768, -32768, -32768, 15));
      dir_tab.push_back(mix_row(32767, 32767, -32768, 32767, 15));
      dir_tab.push_back(mix_row(32767, 0, 0, 0, 1));
      dir_tab.push_back(cfg_row(CSR_MASTER_GAIN, 0));
      dir_tab.push_back(mix_row(32767, -32768, 1, -1, 15, 1'b1, 0));
      dir_tab.push_back(cfg_row(CSR_GAIN_SRC0, 0));
      dir_tab.push_back(cfg_row(CSR_GAIN_SRC1, 16'h4000));
      dir_tab.push_back(cfg_row(CSR_MASTER_GAIN, GAIN_UNITY));
      dir_tab.push_back(mix_row(32767, 32767, -12345, 777, 15));
      dir_tab.push_back(cfg_row(CSR_IDX_UNUSED, 16'hFFFF));
      dir_tab.push_back(mix_row(-32768, 32767, 32767, -32768, 15));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      in_cfg = 1'b0;
      foreach (dir_tab[k]) begin
         row = dir_tab[k];
         if (row.is_cfg) begin
            if (!in_cfg)
               wait_drained();
            csr_write(row.idx, row.wdata);
            in_cfg = 1'b1;
         end else begin
            if (in_cfg) begin
               csr_write_en <= 1'b0;
               in_cfg = 1'b0;
            end
            send_mix(row.item, draw_gap(1'b0), row.typed, row.typed_val);
         end
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         // sender holds off until every expected transfer has come back
         wait_drained();
         csr_write(CSR_GAIN_SRC0, pick_gain(ph));
         csr_write(CSR_GAIN_SRC1, pick_gain(ph));
         csr_write(CSR_GAIN_SRC2, pick_gain(ph));
         csr_write(CSR_GAIN_SRC3, pick_gain(ph));
         csr_write(CSR_MASTER_GAIN, pick_gain(ph));
         csr_write(CSR_MUTE_MASK, (ph < 2 || $urandom_range(0, 1)) ? '0
                                                                    : CSR_DATA_W'($urandom));
         case ($urandom_range(0, 3))
            0: csr_write(CSR_PRIORITY, '0);
            1: csr_write(CSR_PRIORITY, 16'hFFFF);
            default: csr_write(CSR_PRIORITY, CSR_DATA_W'($urandom));
         endcase
         if ($urandom_range(0, 1))
            csr_write(CSR_IDX_UNUSED, CSR_DATA_W'($urandom));
         csr_write_en <= 1'b0;

         burst = 1'b0;
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 40 == 0)
               burst = ($urandom_range(0, 3) == 0);
            for (n = 0; n < NUM_SRC; n++)
               it.smp[n] = rand_sample();
            it.present = NUM_SRC'($urandom);
            send_mix(it, draw_gap(burst), 1'b0, '0);
         end
      end

      wait_drained();
      if (mismatch_count == 0 && mixed_expect_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
